FILE: rtl/msf_pkg.sv
// message slot fifo package: result codes, register indexes, shared structs
// no dependencies; used by msf_out_buf, msf_ctrl, message_slot_fifo and the tb
package msf_pkg;

  localparam int SLOTS_DEF    = 16;
  localparam int ELEM_MAX_DEF = 32;

  localparam int LEN_W   = 7;
  localparam int BYTE_W  = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W   = 7;

  localparam logic [6:0] ELEM_SIZE_RST  = 7'd32;
  localparam logic [4:0] SLOT_COUNT_RST = 5'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_ELEM_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 2'd1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [1:0] ST_DATA   = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_ACCEPT = 2'd3;

  typedef struct packed {
    logic [6:0] elem_size;
    logic [4:0] slot_count;
  } msf_cfg_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              last;
    logic [LEN_W-1:0]  msg_length;
  } msf_res_t;

  // result stage between the sequencer and the output buffer
  typedef struct packed {
    logic     valid;
    logic     from_ram;
    msf_res_t res;
  } msf_stage_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic       pop;
  } msf_buf_t;

endpackage

FILE: rtl/msf_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies
module msf_ram #(
  parameter int W  = 8,
  parameter int D  = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/msf_out_buf.sv
// two-entry output buffer holding finished results until the receiver takes them
// depends on msf_pkg; fed by the result stage of msf_ctrl and the byte ram
module msf_out_buf (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  msf_pkg::msf_stage_t          stg_i,
  input  logic [msf_pkg::BYTE_W-1:0]   ram_rdata_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output msf_pkg::msf_res_t            res_o,
  output msf_pkg::msf_buf_t            buf_o
);

  logic [1:0]        cnt_q, cnt_d;
  msf_pkg::msf_res_t ent0_q, ent0_d;
  msf_pkg::msf_res_t ent1_q, ent1_d;
  msf_pkg::msf_res_t new_res;
  logic              push, pop;

  always_comb begin
    new_res = stg_i.res;
    if (stg_i.from_ram) begin
      new_res.out_byte = ram_rdata_i;
    end
  end

  assign push = stg_i.valid;
  assign pop  = (cnt_q != 2'd0) && !out_stall_i;

  always_comb begin
    cnt_d  = cnt_q;
    ent0_d = ent0_q;
    ent1_d = ent1_q;
    if (pop && push) begin
      if (cnt_q == 2'd1) begin
        ent0_d = new_res;
      end else begin
        ent0_d = ent1_q;
        ent1_d = new_res;
      end
    end else if (pop) begin
      ent0_d = ent1_q;
      cnt_d  = cnt_q - 2'd1;
    end else if (push) begin
      if (cnt_q == 2'd0) begin
        ent0_d = new_res;
      end else begin
        ent1_d = new_res;
      end
      cnt_d = cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent0_q <= ent0_d;
    ent1_q <= ent1_d;
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign res_o       = ent0_q;
  assign buf_o.cnt   = cnt_q;
  assign buf_o.pop   = pop;

endmodule

FILE: rtl/msf_ctrl.sv
// ring pointers, write path and read sequencer of the message slot fifo
// depends on msf_pkg; drives the byte and length rams, feeds msf_out_buf
module msf_ctrl #(
  parameter int SLOTS    = msf_pkg::SLOTS_DEF,
  parameter int ELEM_MAX = msf_pkg::ELEM_MAX_DEF,
  localparam int PW  = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int ABW = (SLOTS * ELEM_MAX > 1) ? $clog2(SLOTS * ELEM_MAX) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  msf_pkg::msf_cfg_t           cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic [msf_pkg::BYTE_W-1:0]  data_byte_i,
  input  logic                        end_of_message_i,
  input  logic [msf_pkg::LEN_W-1:0]   read_count_i,
  input  msf_pkg::msf_buf_t           buf_i,
  output msf_pkg::msf_stage_t         stg_o,
  output logic                        byte_we_o,
  output logic [ABW-1:0]              byte_waddr_o,
  output logic [msf_pkg::BYTE_W-1:0]  byte_wdata_o,
  output logic                        byte_re_o,
  output logic [ABW-1:0]              byte_raddr_o,
  output logic                        len_we_o,
  output logic [PW-1:0]               len_waddr_o,
  output logic [msf_pkg::LEN_W-1:0]   len_wdata_o,
  output logic                        len_re_o,
  output logic [PW-1:0]               len_raddr_o,
  input  logic [msf_pkg::LEN_W-1:0]   len_rdata_i
);

  localparam int OW = $clog2(SLOTS + 1);
  localparam int EW = $clog2(ELEM_MAX + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_LEN   = 3'b010,
    S_BYTES = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [PW-1:0]        head_q, head_d;
  logic [PW-1:0]        tail_q, tail_d;
  logic [PW-1:0]        rslot_q, rslot_d;
  logic [OW-1:0]        occ_q, occ_d;
  logic [EW-1:0]        wpos_q, wpos_d;
  logic                 drop_q, drop_d;
  logic [msf_pkg::LEN_W-1:0] rc_q, rc_d;
  logic [EW-1:0]        n_q, n_d;
  logic [EW-1:0]        idx_q, idx_d;
  msf_pkg::msf_stage_t  stg_q, stg_d;

  logic [OW-1:0]        eff_slots;
  logic [EW-1:0]        eff_elem;
  logic [PW-1:0]        head_next, tail_next;
  logic [EW-1:0]        n_calc;
  logic [2:0]           fill;
  logic                 credit;
  logic                 in_fire;
  logic                 dropping;
  logic [EW-1:0]        wpos_inc;

  // clamp the registers and work out the wrapped pointers and the read length
  always_comb begin
    int s, e, hn, tn, rn;
    s = int'(cfg_i.slot_count);
    if (s < 1) s = 1;
    if (s > SLOTS) s = SLOTS;
    e = int'(cfg_i.elem_size);
    if (e < 1) e = 1;
    if (e > ELEM_MAX) e = ELEM_MAX;
    eff_slots = OW'(s);
    eff_elem  = EW'(e);
    hn = int'(head_q) + 1;
    if (hn >= s) hn = 0;
    tn = int'(tail_q) + 1;
    if (tn >= s) tn = 0;
    head_next = PW'(hn);
    tail_next = PW'(tn);
    rn = int'(rc_q);
    if (int'(len_rdata_i) < rn) rn = int'(len_rdata_i);
    if (rn > ELEM_MAX) rn = ELEM_MAX;
    n_calc = EW'(rn);
  end

  // room for one more result once the stage and the buffer are counted
  assign fill    = 3'(buf_i.cnt) + 3'(stg_q.valid) - 3'(buf_i.pop);
  assign credit  = (fill < 3'd2);
  assign in_stall_o = !((state_q == S_IDLE) && credit);
  assign in_fire = in_valid_i && !in_stall_o;
  assign dropping = drop_q || ((wpos_q == '0) && (occ_q >= eff_slots));
  assign wpos_inc = wpos_q + EW'(1);

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    tail_d  = tail_q;
    rslot_d = rslot_q;
    occ_d   = occ_q;
    wpos_d  = wpos_q;
    drop_d  = drop_q;
    rc_d    = rc_q;
    n_d     = n_q;
    idx_d   = idx_q;
    stg_d   = '0;

    byte_we_o    = 1'b0;
    byte_waddr_o = ABW'(int'(tail_q) * ELEM_MAX + int'(wpos_q));
    byte_wdata_o = data_byte_i;
    byte_re_o    = 1'b0;
    byte_raddr_o = ABW'(int'(rslot_q) * ELEM_MAX + int'(idx_q));
    len_we_o     = 1'b0;
    len_waddr_o  = tail_q;
    len_wdata_o  = msf_pkg::LEN_W'(wpos_q);
    len_re_o     = 1'b0;
    len_raddr_o  = head_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire && op_i == msf_pkg::OP_WRITE) begin
          if (dropping) begin
            drop_d = !end_of_message_i;
            if (end_of_message_i) begin
              wpos_d = '0;
              stg_d.valid          = 1'b1;
              stg_d.res.status     = msf_pkg::ST_FULL;
              stg_d.res.last       = 1'b1;
            end
          end else begin
            logic [EW-1:0] len;
            len = wpos_q;
            if (wpos_q < eff_elem) begin
              byte_we_o = 1'b1;
              len       = wpos_inc;
              wpos_d    = wpos_inc;
            end
            if (end_of_message_i) begin
              len_we_o    = 1'b1;
              len_wdata_o = msf_pkg::LEN_W'(len);
              tail_d      = tail_next;
              occ_d       = occ_q + OW'(1);
              wpos_d      = '0;
              stg_d.valid          = 1'b1;
              stg_d.res.status     = msf_pkg::ST_ACCEPT;
              stg_d.res.last       = 1'b1;
              stg_d.res.msg_length = msf_pkg::LEN_W'(len);
            end
          end
        end else if (in_fire) begin
          if (occ_q == '0) begin
            stg_d.valid      = 1'b1;
            stg_d.res.status = msf_pkg::ST_EMPTY;
            stg_d.res.last   = 1'b1;
          end else begin
            len_re_o = 1'b1;
            rslot_d  = head_q;
            rc_d     = read_count_i;
            head_d   = head_next;
            occ_d    = occ_q - OW'(1);
            state_d  = S_LEN;
          end
        end
      end
      S_LEN: begin
        n_d     = n_calc;
        idx_d   = '0;
        state_d = S_BYTES;
      end
      S_BYTES: begin
        if (credit) begin
          stg_d.valid          = 1'b1;
          stg_d.res.status     = msf_pkg::ST_DATA;
          stg_d.res.msg_length = msf_pkg::LEN_W'(n_q);
          if (n_q == '0) begin
            // zero-length read gives one empty result
            stg_d.res.last = 1'b1;
            state_d        = S_IDLE;
          end else begin
            byte_re_o            = 1'b1;
            stg_d.from_ram       = 1'b1;
            stg_d.res.byte_valid = 1'b1;
            stg_d.res.last       = (idx_q + EW'(1)) == n_q;
            idx_d                = idx_q + EW'(1);
            if ((idx_q + EW'(1)) == n_q) begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      occ_q   <= '0;
      wpos_q  <= '0;
      drop_q  <= 1'b0;
      stg_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      occ_q   <= occ_d;
      wpos_q  <= wpos_d;
      drop_q  <= drop_d;
      stg_q   <= stg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rslot_q <= rslot_d;
    rc_q    <= rc_d;
    n_q     <= n_d;
    idx_q   <= idx_d;
  end

  assign stg_o = stg_q;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OW'(SLOTS))
    else $error("slot occupancy beyond ring size");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_q.valid && buf_i.cnt == 2'd2) |-> buf_i.pop)
    else $error("result landed in a full output buffer");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BYTES && n_q != '0) |-> (idx_q < n_q))
    else $error("byte index past read length");

  a_read_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && op_i == msf_pkg::OP_READ && occ_q != '0) |=> (state_q == S_LEN))
    else $error("read of a filled ring did not fetch the length");

  a_wpos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wpos_q <= EW'(ELEM_MAX))
    else $error("write position beyond slot size");
`endif

endmodule

FILE: rtl/message_slot_fifo.sv
// message slot fifo: ring of fixed-size message slots held in two rams
// input channel: op, data_byte, end_of_message, read_count (valid/stall);
// output channel: status, out_byte, byte_valid, last, msg_length (valid/stall).
// A write transfer moves one message byte a cycle unless the input is stalled;
// only the final byte gives a result (accepted with its stored length, or full
// with no free slot as the message began), via result stage and output buffer.
// A read transfer consumes the head slot: the length ram is read, then the byte
// ram is read one address a cycle while the output buffer has room, and the
// input stays stalled until the last byte of the read has been requested.
// A zero-count read gives one empty data result; a read of an empty ring gives
// one empty status result.
// Configuration (elem_size index 0, slot_count index 1) is always ready and
// may be written only while the block is idle.
// Reset clears the ring pointers, occupancy and write position; slot contents
// stay undefined until written, so no clearing pass is needed.
// When the receiver stalls, results wait in a two-entry output buffer and the
// sequencer holds until there is room; no result is lost.
module message_slot_fifo #(
  parameter int SLOTS    = msf_pkg::SLOTS_DEF,
  parameter int ELEM_MAX = msf_pkg::ELEM_MAX_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           op_i,
  input  logic [msf_pkg::BYTE_W-1:0]     data_byte_i,
  input  logic                           end_of_message_i,
  input  logic [msf_pkg::LEN_W-1:0]      read_count_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     status_o,
  output logic [msf_pkg::BYTE_W-1:0]     out_byte_o,
  output logic                           byte_valid_o,
  output logic                           last_o,
  output logic [msf_pkg::LEN_W-1:0]      msg_length_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [msf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [msf_pkg::CFG_W-1:0]      cfg_data_i
);

  localparam int PW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ABW = (SLOTS * ELEM_MAX > 1) ? $clog2(SLOTS * ELEM_MAX) : 1;

  msf_pkg::msf_cfg_t    cfg_q, cfg_d;
  msf_pkg::msf_stage_t  stg;
  msf_pkg::msf_buf_t    buf_stat;
  msf_pkg::msf_res_t    res;

  logic                          byte_we, byte_re;
  logic [ABW-1:0]                byte_waddr, byte_raddr;
  logic [msf_pkg::BYTE_W-1:0]    byte_wdata, byte_rdata;
  logic                          len_we, len_re;
  logic [PW-1:0]                 len_waddr, len_raddr;
  logic [msf_pkg::LEN_W-1:0]     len_wdata, len_rdata;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        msf_pkg::CFG_ELEM_SIZE:  cfg_d.elem_size  = cfg_data_i;
        msf_pkg::CFG_SLOT_COUNT: cfg_d.slot_count = cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.elem_size  <= msf_pkg::ELEM_SIZE_RST;
      cfg_q.slot_count <= msf_pkg::SLOT_COUNT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  msf_ctrl #(
    .SLOTS    (SLOTS),
    .ELEM_MAX (ELEM_MAX)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .read_count_i     (read_count_i),
    .buf_i            (buf_stat),
    .stg_o            (stg),
    .byte_we_o        (byte_we),
    .byte_waddr_o     (byte_waddr),
    .byte_wdata_o     (byte_wdata),
    .byte_re_o        (byte_re),
    .byte_raddr_o     (byte_raddr),
    .len_we_o         (len_we),
    .len_waddr_o      (len_waddr),
    .len_wdata_o      (len_wdata),
    .len_re_o         (len_re),
    .len_raddr_o      (len_raddr),
    .len_rdata_i      (len_rdata)
  );

  msf_ram #(
    .W (msf_pkg::BYTE_W),
    .D (SLOTS * ELEM_MAX)
  ) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (byte_we),
    .waddr_i (byte_waddr),
    .wdata_i (byte_wdata),
    .re_i    (byte_re),
    .raddr_i (byte_raddr),
    .rdata_o (byte_rdata)
  );

  msf_ram #(
    .W (msf_pkg::LEN_W),
    .D (SLOTS)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (len_waddr),
    .wdata_i (len_wdata),
    .re_i    (len_re),
    .raddr_i (len_raddr),
    .rdata_o (len_rdata)
  );

  msf_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stg_i       (stg),
    .ram_rdata_i (byte_rdata),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res),
    .buf_o       (buf_stat)
  );

  assign status_o     = res.status;
  assign out_byte_o   = res.out_byte;
  assign byte_valid_o = res.byte_valid;
  assign last_o       = res.last;
  assign msg_length_o = res.msg_length;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for message_slot_fifo, directed table rows then random phases
// depends on msf_pkg and message_slot_fifo; results checked against table rows or a predictor

module tb;

  localparam int SLOTS        = msf_pkg::SLOTS_DEF;
  localparam int ELEM_MAX     = msf_pkg::ELEM_MAX_DEF;
  localparam int RANDOM_ITEMS = 450;
  localparam int PHASE_ITEMS  = 50;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       eom;
    logic [6:0] count;
  } msg_item_t;

  typedef struct packed {
    msg_item_t         item;
    logic              typed;
    msf_pkg::msf_res_t want;
  } dir_row_t;

  localparam msf_pkg::msf_res_t NO_RESULT = '0;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic                          in_op;
  logic [msf_pkg::BYTE_W-1:0]    in_data;
  logic                          in_eom;
  logic [msf_pkg::LEN_W-1:0]     in_count;
  logic                          out_valid;
  logic                          out_stall;
  logic [1:0]                    res_status;
  logic [msf_pkg::BYTE_W-1:0]    res_byte;
  logic                          res_byte_valid;
  logic                          res_last;
  logic [msf_pkg::LEN_W-1:0]     res_length;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [msf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [msf_pkg::CFG_W-1:0]     cfg_data;

  // predictor copy of the ring
  logic [7:0] ring_bytes [SLOTS*ELEM_MAX];
  int         ring_len [SLOTS];
  int         head_idx;
  int         tail_idx;
  int         fill;
  int         wr_pos;
  bit         rejecting;
  logic [6:0] elem_reg;
  logic [4:0] slots_reg;

  msf_pkg::msf_res_t step_results [$];
  msf_pkg::msf_res_t due_results [$];
  int                errors;
  int                sent;
  bit                quiet;

  message_slot_fifo u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .op_i             (in_op),
    .data_byte_i      (in_data),
    .end_of_message_i (in_eom),
    .read_count_i     (in_count),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (res_status),
    .out_byte_o       (res_byte),
    .byte_valid_o     (res_byte_valid),
    .last_o           (res_last),
    .msg_length_o     (res_length),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic msf_pkg::msf_res_t mk_res(logic [1:0] st, logic [7:0] b, logic v,
                                               logic l, logic [6:0] len);
    msf_pkg::msf_res_t r;
    r.status     = st;
    r.out_byte   = b;
    r.byte_valid = v;
    r.last       = l;
    r.msg_length = len;
    return r;
  endfunction

  function automatic dir_row_t mk_row(logic op, logic [7:0] data, logic eom, logic [6:0] count,
                                      logic typed, msf_pkg::msf_res_t want);
    dir_row_t row;
    row.item.op    = op;
    row.item.data  = data;
    row.item.eom   = eom;
    row.item.count = count;
    row.typed      = typed;
    row.want       = want;
    return row;
  endfunction

  function automatic int eff_elem();
    int e;
    e = int'(elem_reg);
    if (e < 1) e = 1;
    if (e > ELEM_MAX) e = ELEM_MAX;
    return e;
  endfunction

  function automatic int eff_slots();
    int s;
    s = int'(slots_reg);
    if (s < 1) s = 1;
    if (s > SLOTS) s = SLOTS;
    return s;
  endfunction

  function automatic int step_slot(int s);
    return (s + 1 >= eff_slots()) ? 0 : s + 1;
  endfunction

  // works out the results of one accepted item and advances the ring copy
  task automatic slot_ring_step(input msg_item_t it);
    int h;
    int n;
    if (it.op == msf_pkg::OP_WRITE) begin
      // fullness is judged only as a message begins
      if (wr_pos == 0 && !rejecting && fill >= eff_slots()) rejecting = 1'b1;
      if (rejecting) begin
        if (it.eom) begin
          rejecting = 1'b0;
          wr_pos    = 0;
          step_results.push_back(mk_res(msf_pkg::ST_FULL, 8'h00, 1'b0, 1'b1, 7'd0));
        end
        return;
      end
      if (wr_pos < eff_elem()) begin
        ring_bytes[tail_idx*ELEM_MAX + wr_pos] = it.data;
        wr_pos++;
      end
      if (it.eom) begin
        ring_len[tail_idx] = wr_pos;
        step_results.push_back(mk_res(msf_pkg::ST_ACCEPT, 8'h00, 1'b0, 1'b1,
                                      wr_pos[6:0]));
        tail_idx = step_slot(tail_idx);
        fill++;
        wr_pos = 0;
      end
    end else if (fill == 0) begin
      step_results.push_back(mk_res(msf_pkg::ST_EMPTY, 8'h00, 1'b0, 1'b1, 7'd0));
    end else begin
      h = head_idx;
      n = (int'(it.count) < ring_len[h]) ? int'(it.count) : ring_len[h];
      head_idx = step_slot(head_idx);
      fill--;
      if (n == 0) step_results.push_back(mk_res(msf_pkg::ST_DATA, 8'h00, 1'b0, 1'b1, 7'd0));
      for (int i = 0; i < n; i++)
        step_results.push_back(mk_res(msf_pkg::ST_DATA, ring_bytes[h*ELEM_MAX + i], 1'b1,
                                      i == n - 1, n[6:0]));
    end
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  task automatic check_result(input msf_pkg::msf_res_t got);
    msf_pkg::msf_res_t want;
    if (due_results.size() == 0) begin
      report_mismatch($sformatf("result with none due: status %0d byte %02h",
                                got.status, got.out_byte));
      return;
    end
    want = due_results.pop_front();
    if (got.status !== want.status)
      report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.out_byte !== want.out_byte)
      report_mismatch($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
    if (got.byte_valid !== want.byte_valid)
      report_mismatch($sformatf("byte_valid %0b, want %0b", got.byte_valid, want.byte_valid));
    if (got.last !== want.last)
      report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
    if (got.msg_length !== want.msg_length)
      report_mismatch($sformatf("msg_length %0d, want %0d", got.msg_length, want.msg_length));
  endtask

  // called at a rising edge; returns at the edge of the transfer
  task automatic send_item(input msg_item_t it, input bit typed, input msf_pkg::msf_res_t want);
    int gap;
    bit took;
    gap = quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= it.op;
    in_data  <= it.data;
    in_eom   <= it.eom;
    in_count <= it.count;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    step_results.delete();
    slot_ring_step(it);
    if (typed) due_results.push_back(want);
    else foreach (step_results[i]) due_results.push_back(step_results[i]);
    sent++;
  endtask

  task automatic wait_cfg_transfer();
    bit took;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic set_config(input logic [6:0] elem, input logic [4:0] slots);
    cfg_valid <= 1'b1;
    cfg_index <= msf_pkg::CFG_ELEM_SIZE;
    cfg_data  <= elem;
    wait_cfg_transfer();
    elem_reg = elem;
    cfg_index <= msf_pkg::CFG_SLOT_COUNT;
    cfg_data  <= {2'b00, slots};
    wait_cfg_transfer();
    slots_reg = slots;
    cfg_valid <= 1'b0;
  endtask

  // sender holds off until every due result has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_random_message();
    msg_item_t it;
    int        len;
    int        r;
    r = $urandom_range(0, 9);
    if (r < 6) len = $urandom_range(1, eff_elem() + 1);
    else if (r < 9) len = $urandom_range(1, 3);
    else len = $urandom_range(1, 40);
    for (int k = 0; k < len; k++) begin
      it.op    = msf_pkg::OP_WRITE;
      it.data  = 8'($urandom_range(0, 255));
      it.eom   = (k == len - 1);
      it.count = 7'($urandom_range(0, 127));
      send_item(it, 1'b0, NO_RESULT);
    end
  endtask

  task automatic send_random_read();
    msg_item_t it;
    int        r;
    r = $urandom_range(0, 9);
    it.op   = msf_pkg::OP_READ;
    it.data = 8'($urandom_range(0, 255));
    it.eom  = 1'($urandom_range(0, 1));
    if (r < 5) it.count = 7'($urandom_range(0, eff_elem() + 1));
    else if (r < 7) it.count = 7'd0;
    else it.count = 7'($urandom_range(0, 127));
    send_item(it, 1'b0, NO_RESULT);
  endtask

  // output side: random stall ahead of each transfer
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 12);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  // outputs are stable mid-cycle, so sample there for the coming edge
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (out_valid && !out_stall)
        check_result(mk_res(res_status, res_byte, res_byte_valid, res_last, res_length));
    end
  end

  initial begin
    #30_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int         phase;
    int         phase_base;
    int         random_base;
    int         wr_pct;
    logic [6:0] elem_pick [10];
    logic [4:0] slot_pick [10];
    dir_row_t   rows [$];

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_op     = msf_pkg::OP_WRITE;
    in_data   = '0;
    in_eom    = 1'b0;
    in_count  = '0;
    cfg_valid = 1'b0;
    cfg_index = msf_pkg::CFG_ELEM_SIZE;
    cfg_data  = '0;
    head_idx  = 0;
    tail_idx  = 0;
    fill      = 0;
    wr_pos    = 0;
    rejecting = 1'b0;
    elem_reg  = msf_pkg::ELEM_SIZE_RST;
    slots_reg = msf_pkg::SLOT_COUNT_RST;
    errors    = 0;
    sent      = 0;
    quiet     = 1'b0;
    elem_pick = '{7'd1, 7'd127, 7'd64, 7'd0, 7'd5, 7'd32, 7'd2, 7'd17, 7'd3, 7'd40};
    slot_pick = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd4, 5'd2, 5'd16, 5'd7, 5'd3, 5'd9};

    repeat (12) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    @(posedge clk);

    // three bytes a slot, two slots: truncation and a full ring come cheaply
    set_config(7'd3, 5'd2);
    rows.push_back(mk_row(msf_pkg::OP_READ,  8'h00, 1'b0, 7'd0,   1'b1,
                          mk_res(msf_pkg::ST_EMPTY, 8'h00, 1'b0, 1'b1, 7'd0)));
    rows.push_back(mk_row(msf_pkg::OP_WRITE, 8'h00, 1'b1, 7'd0,   1'b1,
                          mk_res(msf_pkg::ST_ACCEPT, 8'h00, 1'b0, 1'b1, 7'd1)));
    rows.push_back(mk_row(msf_pkg::OP_WRITE, 8'hFF, 1'b0, 7'd127, 1'b0, NO_RESULT));
    rows.push_back(mk_row(msf_pkg::OP_WRITE, 8'h5A, 1'b0, 7'd64,  1'b0, NO_RESULT));
    rows.push_back(mk_row(msf_pkg::OP_WRITE, 8'hA5, 1'b0, 7'd0,   1'b0, NO_RESULT));
    // fourth byte is dropped, so the stored length stays at three
    rows.push_back(mk_row(msf_pkg::OP_WRITE, 8'h3C, 1'b1, 7'd0,   1'b1,
                          mk_res(msf_pkg::ST_ACCEPT, 8'h00, 1'b0, 1'b1, 7'd3)));
    rows.push_back(mk_row(msf_pkg::OP_WRITE, 8'h11, 1'b1, 7'd127, 1'b1,
                          mk_res(msf_pkg::ST_FULL, 8'h00, 1'b0, 1'b1, 7'd0)));
    rows.push_back(mk_row(msf_pkg::OP_WRITE, 8'h22, 1'b0, 7'd0,   1'b0, NO_RESULT));
    rows.push_back(mk_row(msf_pkg::OP_WRITE, 8'h33, 1'b1, 7'd0,   1'b1,
                          mk_res(msf_pkg::ST_FULL, 8'h00, 1'b0, 1'b1, 7'd0)));
    rows.push_back(mk_row(msf_pkg::OP_READ,  8'h00, 1'b0, 7'd0,   1'b1,
                          mk_res(msf_pkg::ST_DATA, 8'h00, 1'b0, 1'b1, 7'd0)));
    rows.push_back(mk_row(msf_pkg::OP_WRITE, 8'h77, 1'b0, 7'd0,   1'b0, NO_RESULT));
    rows.push_back(mk_row(msf_pkg::OP_WRITE, 8'h88, 1'b1, 7'd0,   1'b1,
                          mk_res(msf_pkg::ST_ACCEPT, 8'h00, 1'b0, 1'b1, 7'd2)));
    rows.push_back(mk_row(msf_pkg::OP_READ,  8'h00, 1'b0, 7'd127, 1'b0, NO_RESULT));
    rows.push_back(mk_row(msf_pkg::OP_READ,  8'hFF, 1'b1, 7'd1,   1'b0, NO_RESULT));
    rows.push_back(mk_row(msf_pkg::OP_READ,  8'hFF, 1'b1, 7'd64,  1'b1,
                          mk_res(msf_pkg::ST_EMPTY, 8'h00, 1'b0, 1'b1, 7'd0)));
    rows.push_back(mk_row(msf_pkg::OP_WRITE, 8'h80, 1'b0, 7'd0,   1'b0, NO_RESULT));
    rows.push_back(mk_row(msf_pkg::OP_WRITE, 8'h7F, 1'b1, 7'd0,   1'b1,
                          mk_res(msf_pkg::ST_ACCEPT, 8'h00, 1'b0, 1'b1, 7'd2)));
    rows.push_back(mk_row(msf_pkg::OP_READ,  8'h00, 1'b0, 7'd1,   1'b0, NO_RESULT));
    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].want);

    // each phase starts from an empty ring so no unwritten slot is ever read
    random_base = sent;
    phase = 0;
    while (sent - random_base < RANDOM_ITEMS) begin
      wait_drained();
      set_config(elem_pick[phase % 10], slot_pick[phase % 10]);
      quiet  = (phase % 4 == 2);
      wr_pct = $urandom_range(35, 75);
      phase_base = sent;
      while (sent - phase_base < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < wr_pct) send_random_message();
        else send_random_read();
      end
      while (fill != 0) send_random_read();
      phase++;
    end

    quiet = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/msf_pkg.sv
rtl/msf_ram.sv
rtl/msf_out_buf.sv
rtl/msf_ctrl.sv
rtl/message_slot_fifo.sv
tb/sv/tb.sv
